// ----- rtl/hss_pkg.sv -----
package hss_pkg;

  typedef enum logic [2:0] {
    MODE_NONE         = 3'd0,
    MODE_OFF          = 3'd1,
    MODE_PAUSED       = 3'd2,
    MODE_WOOD_HOUSE   = 3'd3,
    MODE_BUFFER_HOUSE = 3'd4,
    MODE_GAS_HOUSE    = 3'd5,
    MODE_WOOD_BUFFER  = 3'd6
  } mode_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;
  localparam int TempWidth     = 12;
  localparam int BandWidth     = 8;
  localparam int DwellWidth    = 16;
  localparam int TimeWidth     = 32;
  // threshold sums: 12-bit signed plus or minus 8-bit unsigned
  localparam int SumWidth      = TempWidth + 2;

  localparam logic [CfgIndexWidth-1:0] REG_AUTO_MODE       = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_WOOD_MIN_TEMP   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_BUFFER_MIN_TEMP = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HYSTERESIS_BAND = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_DWELL_MS        = 3'd4;

  localparam logic                        AUTO_MODE_RESET       = 1'b1;
  localparam logic signed [TempWidth-1:0] WOOD_MIN_TEMP_RESET   = 12'sd800;
  localparam logic signed [TempWidth-1:0] BUFFER_MIN_TEMP_RESET = 12'sd800;
  localparam logic [BandWidth-1:0]        HYSTERESIS_BAND_RESET = 8'd32;
  localparam logic [DwellWidth-1:0]       DWELL_MS_RESET        = 16'd500;

  typedef struct packed {
    logic taps;
    logic gas;
    logic buffer;
    logic wood;
  } act_t;

endpackage

// ----- rtl/heat_source_selector.sv -----
// Heat source selector. Each input beat is one evaluation of the automatic
// or manual rules against the registered mode; the block accepts one beat
// per cycle unless a stalled result backs up the input register, and
// delivers one result beat per input beat (input register, then one pass of
// compare and select logic into the result register, which also holds the
// mode and actuator state). The mode written by one evaluation is the mode
// the next evaluation sees. A stalled result holds the result register while
// the input register takes one more beat. Configuration writes take effect
// on the next edge; the user must make them while the block is idle, unenforced.
module heat_source_selector
  import hss_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [CfgIndexWidth-1:0]        cfg_index,
  input  logic [CfgDataWidth-1:0]         cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [TimeWidth-1:0]            now_ms,
  input  logic signed [TempWidth-1:0]     wood_temp,
  input  logic signed [TempWidth-1:0]     buffer_top_temp,
  input  logic signed [TempWidth-1:0]     buffer_bottom_temp,
  input  logic                            house_demand,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      mode_state,
  output logic                            wood_pump_on,
  output logic                            buffer_pump_on,
  output logic                            gas_furnace_on,
  output logic                            taps_alternate,
  output logic                            state_changed
);

  logic                        auto_mode;
  logic signed [TempWidth-1:0] wood_min_temp;
  logic signed [TempWidth-1:0] buffer_min_temp;
  logic [BandWidth-1:0]        hysteresis_band;
  logic [DwellWidth-1:0]       dwell_ms;

  logic                        in_valid_q;
  logic [TimeWidth-1:0]        now_q;
  logic signed [TempWidth-1:0] wood_q;
  logic signed [TempWidth-1:0] top_q;
  logic signed [TempWidth-1:0] bottom_q;
  logic                        demand_q;

  logic [TimeWidth-1:0]        last_change_time;

  logic                        advance;
  logic                        evaluate;
  logic signed [SumWidth-1:0]  band_ext;
  logic signed [SumWidth-1:0]  wood_hi;
  logic signed [SumWidth-1:0]  wood_lo;
  logic signed [SumWidth-1:0]  buf_hi;
  logic signed [SumWidth-1:0]  buf_lo;
  logic signed [SumWidth-1:0]  wood_ext;
  logic signed [SumWidth-1:0]  top_ext;
  logic [TimeWidth-1:0]        elapsed;
  logic                        dwell_ok;
  logic                        has_want;
  mode_t                       want;
  logic                        change_ok;
  act_t                        act_cur;
  act_t                        act_next;

  // output register frees when empty or being taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_valid_q || advance;
  assign evaluate = in_valid_q && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode       <= AUTO_MODE_RESET;
      wood_min_temp   <= WOOD_MIN_TEMP_RESET;
      buffer_min_temp <= BUFFER_MIN_TEMP_RESET;
      hysteresis_band <= HYSTERESIS_BAND_RESET;
      dwell_ms        <= DWELL_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_MODE:       auto_mode       <= cfg_data[0];
        REG_WOOD_MIN_TEMP:   wood_min_temp   <= cfg_data[TempWidth-1:0];
        REG_BUFFER_MIN_TEMP: buffer_min_temp <= cfg_data[TempWidth-1:0];
        REG_HYSTERESIS_BAND: hysteresis_band <= cfg_data[BandWidth-1:0];
        REG_DWELL_MS:        dwell_ms        <= cfg_data[DwellWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      now_q    <= now_ms;
      wood_q   <= wood_temp;
      top_q    <= buffer_top_temp;
      bottom_q <= buffer_bottom_temp;
      demand_q <= house_demand;
    end
  end

  assign band_ext = $signed({{(SumWidth-BandWidth){1'b0}}, hysteresis_band});
  assign wood_ext = SumWidth'(wood_q);
  assign top_ext  = SumWidth'(top_q);
  assign wood_hi  = SumWidth'(wood_min_temp) + band_ext;
  assign wood_lo  = SumWidth'(wood_min_temp) - band_ext;
  assign buf_hi   = SumWidth'(buffer_min_temp) + band_ext;
  assign buf_lo   = SumWidth'(buffer_min_temp) - band_ext;

  assign elapsed  = now_q - last_change_time;
  assign dwell_ok = elapsed >= {{(TimeWidth-DwellWidth){1'b0}}, dwell_ms};

  // first rule of the chain that fires wins; no change if it names the mode
  always_comb begin
    want     = MODE_NONE;
    has_want = 1'b0;
    if (auto_mode) begin
      has_want = 1'b1;
      if (demand_q) begin
        if (wood_ext > wood_hi) begin
          want = MODE_WOOD_HOUSE;
        end else if (mode_state == MODE_WOOD_HOUSE && wood_ext < wood_lo) begin
          want = MODE_PAUSED;
        end else if (top_ext > buf_hi) begin
          want = MODE_BUFFER_HOUSE;
        end else if (mode_state == MODE_BUFFER_HOUSE && top_ext < buf_lo) begin
          want = MODE_PAUSED;
        end else if (mode_state != MODE_WOOD_HOUSE && mode_state != MODE_BUFFER_HOUSE) begin
          want = MODE_GAS_HOUSE;
        end else begin
          has_want = 1'b0;
        end
      end else if (wood_q >= bottom_q) begin
        want = MODE_WOOD_BUFFER;
      end else begin
        want = MODE_PAUSED;
      end
    end else if ((mode_state == MODE_WOOD_HOUSE && wood_q < wood_min_temp) ||
                 (mode_state == MODE_BUFFER_HOUSE && top_q < buffer_min_temp) ||
                 (mode_state == MODE_WOOD_BUFFER &&
                  (wood_q < wood_min_temp || wood_q < bottom_q))) begin
      want     = MODE_PAUSED;
      has_want = 1'b1;
    end
  end

  assign change_ok = has_want && (mode_state != want) && dwell_ok;

  assign act_cur = '{taps: taps_alternate, gas: gas_furnace_on,
                     buffer: buffer_pump_on, wood: wood_pump_on};

  always_comb begin
    act_next = '0;
    unique case (want)
      MODE_PAUSED: begin
        // drop only the source of the mode being left
        act_next = act_cur;
        case (mode_state) inside
          MODE_GAS_HOUSE:                    act_next.gas    = 1'b0;
          MODE_WOOD_HOUSE, MODE_WOOD_BUFFER: act_next.wood   = 1'b0;
          MODE_BUFFER_HOUSE:                 act_next.buffer = 1'b0;
          default: ;
        endcase
      end
      MODE_WOOD_HOUSE:   act_next.wood = 1'b1;
      MODE_BUFFER_HOUSE: begin
        act_next.taps   = 1'b1;
        act_next.buffer = 1'b1;
      end
      MODE_GAS_HOUSE:    act_next.gas = 1'b1;
      MODE_WOOD_BUFFER:  begin
        act_next.taps = 1'b1;
        act_next.wood = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      state_changed    <= 1'b0;
      mode_state       <= MODE_NONE;
      wood_pump_on     <= 1'b0;
      buffer_pump_on   <= 1'b0;
      gas_furnace_on   <= 1'b0;
      taps_alternate   <= 1'b0;
      last_change_time <= '0;
    end else if (advance) begin
      out_valid <= in_valid_q;
      if (in_valid_q) begin
        state_changed <= change_ok;
        if (change_ok) begin
          mode_state       <= want;
          wood_pump_on     <= act_next.wood;
          buffer_pump_on   <= act_next.buffer;
          gas_furnace_on   <= act_next.gas;
          taps_alternate   <= act_next.taps;
          last_change_time <= now_q;
        end
      end
    end
  end

  a_eval_delivers: assert property (@(posedge clk) disable iff (rst)
    evaluate |=> out_valid)
    else $error("evaluated beat did not reach the result register");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("stalled input beat was lost");

  a_change_moves_mode: assert property (@(posedge clk) disable iff (rst)
    (evaluate && change_ok) |=> (mode_state != $past(mode_state)))
    else $error("accepted change left the mode unchanged");

  a_gas_alone: assert property (@(posedge clk) disable iff (rst)
    (mode_state == MODE_GAS_HOUSE) |->
      (gas_furnace_on && !wood_pump_on && !buffer_pump_on && !taps_alternate))
    else $error("gas-house mode with wrong actuators");

endmodule
